/* src/brf_pkg.sv */
package brf_pkg;

	localparam int MAX_DEPTH_DEF = 256;
	localparam int CAP_W         = 9;
	localparam int CAP_RST       = 256;
	localparam int APB_AW        = 3;
	localparam int APB_DW        = 32;
	localparam int BYTE_W        = 8;
	localparam int FILL_W        = 8;
	localparam int MODE_W        = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_CAP = 1'b0;

	typedef struct packed {
		logic start;     // input beat taken: run the op, read the ring
		logic load_out;  // move the result into the output register
	} brf_cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being drained
	} brf_sts_t;

endpackage

/* src/brf_ctrl.sv */
module brf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  brf_pkg::brf_sts_t sts,
	output brf_pkg::brf_cmd_t cmd
);
	import brf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait here while the previous result is still held
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* src/brf_dp.sv */
module brf_dp #(
	parameter int MAX_DEPTH = brf_pkg::MAX_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brf_pkg::brf_cmd_t             cmd,
	output brf_pkg::brf_sts_t             sts,
	input  logic [brf_pkg::MODE_W-1:0]    in_mode,
	input  logic [brf_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          cfg_we,
	input  logic [brf_pkg::CAP_W-1:0]     cfg_wdata,
	output logic [brf_pkg::CAP_W-1:0]     cap,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [brf_pkg::BYTE_W-1:0]    out_byte,
	output logic                          out_ok,
	output logic [brf_pkg::FILL_W-1:0]    out_fill
);
	import brf_pkg::*;

	localparam int PW = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
	localparam int LW = PW + 1;

	logic [BYTE_W-1:0] mem [MAX_DEPTH];

	logic [CAP_W-1:0]  cap_q;
	logic [PW-1:0]     wr_q, rd_q;
	logic [MODE_W-1:0] mode_s1;
	logic              ok_s1;
	logic [BYTE_W-1:0] rdata_q;
	logic              oval_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              ook_q;
	logic [FILL_W-1:0] ofill_q;

	logic [31:0]       cap32;
	logic [LW-1:0]     len;
	logic [LW-1:0]     wr_inc, rd_inc;
	logic [PW-1:0]     wr_nxt, rd_nxt;
	logic [LW-1:0]     held;
	logic              full, empty, op_ok;

	// effective ring length: register saturated to 2..MAX_DEPTH
	always_comb begin
		cap32 = 32'(cap_q);
		if (cap32 < 32'd2)
			len = LW'(2);
		else if (cap32 > 32'(MAX_DEPTH))
			len = LW'(MAX_DEPTH);
		else
			len = LW'(cap32);
	end

	assign wr_inc = LW'(wr_q) + LW'(1);
	assign rd_inc = LW'(rd_q) + LW'(1);
	assign wr_nxt = (wr_inc >= len) ? '0 : wr_inc[PW-1:0];
	assign rd_nxt = (rd_inc >= len) ? '0 : rd_inc[PW-1:0];
	assign full   = (wr_nxt == rd_q);
	assign empty  = (wr_q == rd_q);

	always_comb begin
		case (in_mode)
			MODE_PUSH:  op_ok = !full;
			MODE_POP:   op_ok = !empty;
			MODE_FLUSH: op_ok = 1'b1;
			default:    op_ok = 1'b0;
		endcase
	end

	// count by conditional add of the length
	assign held = (wr_q >= rd_q) ? (LW'(wr_q) - LW'(rd_q))
	                             : (len + LW'(wr_q) - LW'(rd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(CAP_RST);
			wr_q   <= '0;
			rd_q   <= '0;
			oval_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
				wr_q  <= '0;
				rd_q  <= '0;
			end else if (cmd.start && op_ok) begin
				case (in_mode)
					MODE_PUSH:  wr_q <= wr_nxt;
					MODE_POP:   rd_q <= rd_nxt;
					MODE_FLUSH: begin
						wr_q <= '0;
						rd_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.load_out)
				oval_q <= 1'b1;
			else if (out_ready)
				oval_q <= 1'b0;
		end
	end

	// ring storage and per-op payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rdata_q <= mem[rd_q];
			mode_s1 <= in_mode;
			ok_s1   <= op_ok;
			if (in_mode == MODE_PUSH && op_ok)
				mem[wr_q] <= in_byte;
		end
		if (cmd.load_out) begin
			obyte_q <= (mode_s1 == MODE_POP && ok_s1) ? rdata_q : '0;
			ook_q   <= ok_s1;
			ofill_q <= FILL_W'(held);
		end
	end

	assign sts.out_free = !oval_q || out_ready;
	assign cap          = cap_q;
	assign out_valid    = oval_q;
	assign out_byte     = obyte_q;
	assign out_ok       = ook_q;
	assign out_fill     = ofill_q;

endmodule

/* src/byte_ring_fifo_core.sv */
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tdata: data_in[7:0]; tuser: mode[1:0]
// m_axis    out  tdata: data_out[7:0], fill_count[15:8]; tuser: ok
// apb       in   reg 0 at 0x0: capacity_in_use[8:0]
//
// Each beat runs the op and reads the ring memory as ST_IDLE takes it, then
// loads the output register in ST_EXEC; the next beat is taken after that.
// A stalled m_tready holds the op in ST_EXEC until the output frees.
// Reset clears both positions and sets capacity_in_use to 256; ring contents
// are not cleared. A length write also clears both positions.
module byte_ring_fifo_core #(
	parameter int MAX_DEPTH = brf_pkg::MAX_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // data_in[7:0]
	input  logic [1:0]                   s_tuser,   // mode[1:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,   // data_out[7:0], fill_count[15:8]
	output logic [0:0]                   m_tuser,   // ok
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [brf_pkg::APB_AW-1:0]   paddr,
	input  logic [brf_pkg::APB_DW-1:0]   pwdata,
	output logic [brf_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import brf_pkg::*;

	brf_cmd_t          cmd;
	brf_sts_t          sts;
	logic              cfg_we;
	logic [CAP_W-1:0]  cap;
	logic [BYTE_W-1:0] out_byte;
	logic              out_ok;
	logic [FILL_W-1:0] out_fill;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAP);
	assign prdata = (paddr[2] == REG_CAP) ? APB_DW'(cap) : '0;

	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brf_dp #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_mode   (s_tuser),
		.in_byte   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[CAP_W-1:0]),
		.cap       (cap),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_ok    (out_ok),
		.out_fill  (out_fill)
	);

	assign m_tdata = {out_fill, out_byte};
	assign m_tuser = out_ok;

endmodule

/* bench/tb_byte_ring_fifo_core.sv */
module tb_byte_ring_fifo_core;
	import brf_pkg::*;

	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;   // unused opcode, no state change
	localparam logic [APB_AW-1:0] CAP_ADDR   = 3'h0;
	localparam logic [APB_AW-1:0] SPARE_ADDR = 3'h4;  // decodes to a register that is not there
	localparam int RING_SLOTS = MAX_DEPTH_DEF;
	localparam int LIMIT      = 400000;

	typedef struct packed {
		logic [BYTE_W-1:0] val;
		logic              ok;
		logic [FILL_W-1:0] fill;
	} ring_result_t;

	class ring_scoreboard;
		logic [BYTE_W-1:0] slots [RING_SLOTS];
		logic [CAP_W-1:0]  cap_reg;
		int unsigned       wr_pos, rd_pos;
		ring_result_t      pending_results [$];
		int errors, n_ops, n_push_full, n_pop_empty, n_flush, n_len, peak_fill;

		function void reset_state();
			cap_reg = CAP_W'(CAP_RST);
			wr_pos = 0;
			rd_pos = 0;
			pending_results.delete();
		endfunction

		function int unsigned ring_len();
			int unsigned len;
			len = 32'(cap_reg);
			if (len < 2) len = 2;
			if (len > RING_SLOTS) len = RING_SLOTS;
			return len;
		endfunction

		function int unsigned held(int unsigned len);
			return (wr_pos >= rd_pos) ? wr_pos - rd_pos : len + wr_pos - rd_pos;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void write_reg(logic idx, logic [APB_DW-1:0] v);
			if (idx != REG_CAP) return;
			cap_reg = v[CAP_W-1:0];
			wr_pos = 0;
			rd_pos = 0;
			n_len++;
		endfunction

		// accepted input beat: advance the ring and queue the result it gives
		function void take_op(logic [MODE_W-1:0] op, logic [BYTE_W-1:0] din);
			int unsigned len, nxt;
			ring_result_t e;
			len = ring_len();
			if (wr_pos >= len) wr_pos = 0;
			if (rd_pos >= len) rd_pos = 0;
			e = '0;
			n_ops++;
			case (op)
				MODE_PUSH: begin
					nxt = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
					if (nxt != rd_pos) begin
						slots[wr_pos] = din;
						wr_pos = nxt;
						e.ok = 1'b1;
					end else begin
						n_push_full++;
					end
				end
				MODE_POP: begin
					if (rd_pos != wr_pos) begin
						e.val = slots[rd_pos];
						rd_pos = (rd_pos + 1 >= len) ? 0 : rd_pos + 1;
						e.ok = 1'b1;
					end else begin
						n_pop_empty++;
					end
				end
				MODE_FLUSH: begin
					wr_pos = 0;
					rd_pos = 0;
					e.ok = 1'b1;
					n_flush++;
				end
				default: ;
			endcase
			e.fill = FILL_W'(held(len));
			if (held(len) > peak_fill) peak_fill = held(len);
			pending_results.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_beat(logic [15:0] td, logic [0:0] tu);
			ring_result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("result beat with nothing pending: tdata=%h tuser=%b", td, tu));
				return;
			end
			e = pending_results.pop_front();
			if (td[7:0] !== e.val)
				report($sformatf("data_out got %h want %h", td[7:0], e.val));
			if (tu[0] !== e.ok)
				report($sformatf("ok got %b want %b", tu[0], e.ok));
			if (td[15:8] !== e.fill)
				report($sformatf("fill_count got %0d want %0d", td[15:8], e.fill));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // data_in[7:0]
	logic [1:0]        s_tuser;   // mode[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // data_out[7:0], fill_count[15:8]
	logic [0:0]        m_tuser;   // ok
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	ring_scoreboard sb;
	bit             calm;
	int             cycles;

	byte_ring_fifo_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// mostly short gaps, a few long ones; none at all while calm
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tuser);
	end

	initial begin
		int run, stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// valid stays high after the beat is taken; callers lower it via settle
	task automatic send_op(input logic [MODE_W-1:0] op, input logic [BYTE_W-1:0] din);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= din;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.take_op(op, din);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(addr[2], v);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_cap();
		logic [APB_DW-1:0] rd;
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= CAP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd[CAP_W-1:0] !== sb.cap_reg)
			sb.report($sformatf("capacity_in_use read %0d want %0d", rd[CAP_W-1:0], sb.cap_reg));
	endtask

	task automatic set_length(input logic [APB_AW-1:0] addr, input logic [CAP_W-1:0] v);
		settle();
		apb_write(addr, APB_DW'(v));
		check_cap();
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] len_val, input int n, input int prefill,
		input bit quiet);
		int burst_left, r;
		bit push_heavy;
		logic [MODE_W-1:0] op;
		set_length(CAP_ADDR, len_val);
		calm = quiet;
		burst_left = 0;
		push_heavy = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i < prefill) begin
				op = MODE_PUSH;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					push_heavy = 1'($urandom_range(0, 1));
				end
				burst_left--;
				r = $urandom_range(0, 99);
				if (r < 3) op = MODE_FLUSH;
				else if (r < 6) op = MODE_NONE;
				else if (r < 80) op = push_heavy ? MODE_PUSH : MODE_POP;
				else op = push_heavy ? MODE_POP : MODE_PUSH;
			end
			send_op(op, BYTE_W'($urandom));
		end
		calm = 1'b0;
	endtask

	initial begin
		sb = new;
		sb.reset_state();
		calm     = 1'b0;
		cycles   = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= MODE_PUSH;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_cap();

		// full-length ring from reset: empty pop, unused op, byte extremes, flush
		send_op(MODE_POP,   8'h00);
		send_op(MODE_NONE,  8'hff);
		send_op(MODE_PUSH,  8'h00);
		send_op(MODE_PUSH,  8'hff);
		send_op(MODE_PUSH,  8'ha5);
		send_op(MODE_NONE,  8'h00);
		send_op(MODE_POP,   8'hff);
		send_op(MODE_POP,   8'h00);
		send_op(MODE_PUSH,  8'h5a);
		send_op(MODE_FLUSH, 8'hff);
		send_op(MODE_POP,   8'h00);
		send_op(MODE_PUSH,  8'h3c);

		// smallest ring holds one byte
		set_length(CAP_ADDR, 9'd2);
		send_op(MODE_PUSH,  8'h81);
		send_op(MODE_PUSH,  8'h7e);
		send_op(MODE_NONE,  8'h7e);
		send_op(MODE_POP,   8'h00);
		send_op(MODE_POP,   8'h00);

		// write to a nonexistent register must keep length and pointers
		send_op(MODE_PUSH,  8'h11);
		set_length(SPARE_ADDR, 9'd5);
		send_op(MODE_PUSH,  8'h22);
		send_op(MODE_POP,   8'h00);
		send_op(MODE_FLUSH, 8'h00);

		// length below range saturates to 2
		set_length(CAP_ADDR, 9'd1);
		send_op(MODE_PUSH,  8'h44);
		send_op(MODE_PUSH,  8'h55);
		send_op(MODE_POP,   8'h00);

		run_phase(9'd3,   40, 0,   1'b0);
		run_phase(9'd2,   30, 0,   1'b1);
		run_phase(9'd9,   40, 0,   1'b0);
		run_phase(9'd1,   20, 0,   1'b0);
		run_phase(9'd33,  50, 0,   1'b0);
		// above range saturates to 256: fill to 255 and bounce off full
		run_phase(9'd511, 290, 258, 1'b0);
		run_phase(9'd255, 30, 0,   1'b1);
		run_phase(9'($urandom_range(4, 40)), 40, 0, 1'b0);
		run_phase(9'd0,   15, 0,   1'b0);

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d ops over %0d length writes, %0d flushes, peak fill %0d",
			sb.n_ops, sb.n_len, sb.n_flush, sb.peak_fill);
		$display("refused %0d pushes on full and %0d pops on empty, %0d mismatches",
			sb.n_push_full, sb.n_pop_empty, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
